/* sv/assert_macros.svh */
// Assertion macros shared by the selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, expr) \
    `ASSERT_PROP(label, clk, rst_n, !(expr))

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* sv/rps_pkg.sv */
// Shared types, constants and helpers of the redundant packet selector.
package rps_pkg;

    localparam int SEQ_W          = 16;
    localparam int SLOT_W         = 4;
    localparam int RED_W          = 5;
    localparam int MAX_REDUNDANCY = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = QPTR_W + 1;

    localparam logic [RED_W-1:0] R_CAP =
        (MAX_REDUNDANCY < 16) ? RED_W'(MAX_REDUNDANCY) : RED_W'(16);

    typedef logic [SEQ_W-1:0]  seq_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [RED_W-1:0]  red_t;

    // run request from the front part into the queue
    typedef struct packed {
        logic  push;
        slot_t start;
    } run_push_t;

    // queue head as seen by the back part
    typedef struct packed {
        logic  empty;
        logic  full;
        slot_t start;
    } run_head_t;

    function automatic red_t effective_r(input red_t r);
        red_t res;
        res = r;
        if (res == '0)
        begin
            res = RED_W'(1);
        end
        if (res > R_CAP)
        begin
            res = R_CAP;
        end
        return res;
    endfunction

endpackage

/* sv/rps_front.sv */
// Front part: takes sequence numbers, tracks the datagram and picks the start slot.
`include "assert_macros.svh"

module rps_front
    import rps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  seq_t      sub_seq,
    input  red_t      redundancy,
    input  logic      queue_full,
    output run_push_t run_push
);

    seq_t  last_accepted_reg, last_accepted_next;
    seq_t  newest_seen_reg, newest_seen_next;
    slot_t slot_counter_reg, slot_counter_next;
    slot_t chosen_slot_reg, chosen_slot_next;
    logic  match_found_reg, match_found_next;

    logic  accept;
    red_t  r_eff;
    slot_t r_last;
    seq_t  expected;
    logic  hit;
    logic  matched;
    slot_t chosen_now;
    logic  final_item;
    seq_t  newest_now;

    assign s_tready   = !queue_full;
    assign accept     = s_tvalid && s_tready;
    assign r_eff      = effective_r(redundancy);
    assign r_last     = SLOT_W'(r_eff - RED_W'(1));
    assign expected   = last_accepted_reg + SEQ_W'(1);
    assign hit        = !match_found_reg && (sub_seq == expected);
    assign matched    = match_found_reg || hit;
    assign chosen_now = match_found_reg ? chosen_slot_reg : slot_counter_reg;
    assign final_item = slot_counter_reg >= r_last;
    assign newest_now = (slot_counter_reg == '0) ? sub_seq : newest_seen_reg;

    assign run_push.push  = accept && final_item;
    assign run_push.start = matched ? chosen_now : r_last;

    always_comb
    begin
        last_accepted_next = last_accepted_reg;
        newest_seen_next   = newest_seen_reg;
        slot_counter_next  = slot_counter_reg;
        chosen_slot_next   = chosen_slot_reg;
        match_found_next   = match_found_reg;
        if (accept)
        begin
            newest_seen_next = newest_now;
            if (final_item)
            begin
                last_accepted_next = newest_now;
                slot_counter_next  = '0;
                chosen_slot_next   = '0;
                match_found_next   = 1'b0;
            end
            else
            begin
                slot_counter_next = slot_counter_reg + SLOT_W'(1);
                chosen_slot_next  = matched ? chosen_now : chosen_slot_reg;
                match_found_next  = matched;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_accepted_reg <= '0;
            newest_seen_reg   <= '0;
            slot_counter_reg  <= '0;
            chosen_slot_reg   <= '0;
            match_found_reg   <= 1'b0;
        end
        else
        begin
            last_accepted_reg <= last_accepted_next;
            newest_seen_reg   <= newest_seen_next;
            slot_counter_reg  <= slot_counter_next;
            chosen_slot_reg   <= chosen_slot_next;
            match_found_reg   <= match_found_next;
        end
    end

    `ASSERT_NEVER(a_push_when_full, clk, rst_n, run_push.push && queue_full)
    `ASSERT_PROP(a_final_clears, clk, rst_n, run_push.push |=> (slot_counter_reg == '0 && !match_found_reg))
    `ASSERT_PROP(a_chosen_in_run, clk, rst_n, match_found_reg |-> (chosen_slot_reg < slot_counter_reg))

endmodule

/* sv/rps_queue.sv */
// Short run queue between the front and back parts.
`include "assert_macros.svh"

module rps_queue
    import rps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  run_push_t run_push,
    input  logic      pop,
    output run_head_t run_head
);

    slot_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign run_head.empty = (count_reg == '0);
    assign run_head.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign run_head.start = mem_reg[rd_ptr_reg];
    assign do_pop         = pop && !run_head.empty;

    always_comb
    begin
        count_next = count_reg;
        if (run_push.push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!run_push.push && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_push.push)
        begin
            mem_reg[wr_ptr_reg] <= run_push.start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (run_push.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > QCNT_W'(QUEUE_DEPTH))
    `ASSERT_PROP(a_ptr_gap, clk, rst_n, QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg))
    `ASSERT_PROP(a_push_only_grows, clk, rst_n, (run_push.push && !do_pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))

endmodule

/* sv/rps_back.sv */
// Back part: expands each queued run into slot indices, oldest first.
`include "assert_macros.svh"

module rps_back
    import rps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  run_head_t run_head,
    output logic      pop,
    output logic      m_tvalid,
    input  logic      m_tready,
    output slot_t     slot_index,
    output logic      last_of_run
);

    logic  run_active_reg;
    slot_t cur_reg;
    logic  out_valid_reg;
    slot_t out_slot_reg;
    logic  out_last_reg;
    logic  out_free;

    assign out_free    = !out_valid_reg || m_tready;
    assign pop         = out_free && !run_active_reg && !run_head.empty;
    assign m_tvalid    = out_valid_reg;
    assign slot_index  = out_slot_reg;
    assign last_of_run = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (run_active_reg)
            begin
                out_slot_reg <= cur_reg;
                out_last_reg <= (cur_reg == '0);
                cur_reg      <= cur_reg - SLOT_W'(1);
            end
            else if (!run_head.empty)
            begin
                out_slot_reg <= run_head.start;
                out_last_reg <= (run_head.start == '0);
                cur_reg      <= run_head.start - SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (out_free)
        begin
            if (run_active_reg)
            begin
                out_valid_reg  <= 1'b1;
                run_active_reg <= (cur_reg != '0);
            end
            else if (!run_head.empty)
            begin
                out_valid_reg  <= 1'b1;
                run_active_reg <= (run_head.start != '0);
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_PROP(a_run_has_output, clk, rst_n, run_active_reg |-> out_valid_reg)
    `ASSERT_PROP(a_run_ends_on_last, clk, rst_n, (out_valid_reg && out_last_reg) |-> !run_active_reg)
    `ASSERT_PROP(a_count_down, clk, rst_n, (out_valid_reg && m_tready && run_active_reg) |=> (out_slot_reg == $past(out_slot_reg) - SLOT_W'(1)))

endmodule

/* sv/redundant_packet_selector.sv */
// Top level of the redundant packet selector.
// One sub-packet sequence number is taken per clock while the run queue is not full,
// slot 0 (newest) first; the slot count per datagram comes from the redundancy register
// (0 reads as 1, above 16 reads as 16). On the final slot of a datagram the front part
// picks the first slot whose number is one past the last accepted datagram (slot R-1 if
// none) and queues it; the back part then emits one slot index per clock while m_tready
// is high, from that slot down to 0, tlast on slot 0. The four-entry run queue lets the
// input keep going at one item per clock until it fills, so while m_tready stays high,
// sustained input is one item per cycle; a datagram of R items yields at most R results.
module redundant_packet_selector
    import rps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,      // redundancy
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // sub_seq
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,        // slot_index[3:0], zero fill
    output logic        m_tlast         // last_of_run
);

    red_t      redundancy_reg;
    run_push_t run_push;
    run_head_t run_head;
    logic      pop;
    slot_t     slot_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            redundancy_reg <= RED_W'(1);
        end
        else if (cfg_we)
        begin
            redundancy_reg <= cfg_wdata;
        end
    end

    rps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .sub_seq    (s_tdata),
        .redundancy (redundancy_reg),
        .queue_full (run_head.full),
        .run_push   (run_push)
    );

    rps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .run_push (run_push),
        .pop      (pop),
        .run_head (run_head)
    );

    rps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .run_head    (run_head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .slot_index  (slot_index),
        .last_of_run (m_tlast)
    );

    assign m_tdata = {4'b0000, slot_index};

endmodule
